/* rtl/pvsc_pkg.sv */
// Shared types and constants for the PID valve step controller.
// No dependencies.
package pvsc_pkg;

  // Field widths
  localparam int FLOW_W   = 24;   // Q16.8 flow and set point
  localparam int ERR_W    = 25;   // Q17.8 error
  localparam int DERIV_W  = 26;   // Q18.8 derivative
  localparam int INTEG_W  = 15;   // Q.8 integral, clamped to +/-50.0
  localparam int GAIN_W   = 16;   // Q8.8 gains
  localparam int TOL_W    = 23;
  localparam int CNT_W    = 16;
  localparam int STEP_W   = 12;
  localparam int DRIVE_W  = 44;   // Q.16 sum of three products
  localparam int CFG_DW   = 24;
  localparam int CFG_IW   = 3;

  // Arithmetic limits
  localparam int STEP_SATURATION = 4095;
  localparam int INTEG_LIMIT     = 12800;      // 50.0 in Q.8
  localparam int DEADBAND_Q8     = 256;        // 1.0 in Q.8
  localparam int MIN_DRIVE_INT   = 10;         // 10.0, compared on whole units
  localparam int RUN_STEP_LIMIT  = 50;
  localparam int STEP_FIELD_MAX  = 4095;
  localparam int DIV5_MUL        = 205;        // floor(x/5) = (x*205)>>10, x < 1024
  localparam int DIV5_SHIFT      = 10;
  localparam int RUN_DIV_SPAN    = 255;        // whole units at or above: steps clamp

  typedef enum logic [CFG_IW-1:0] {
    REG_SET_POINT    = 3'd0,
    REG_GAIN_P       = 3'd1,
    REG_GAIN_I       = 3'd2,
    REG_GAIN_D       = 3'd3,
    REG_SETTLE_MODE  = 3'd4,
    REG_SETTLE_TOL   = 3'd5,
    REG_COUNT_TARGET = 3'd6
  } cfg_reg_t;

endpackage

/* rtl/pid_valve_step_controller_top.sv */
// PID valve step controller, top level.
// Depends on pvsc_pkg.
//
// One flow sample (signed Q16.8) enters per beat on the s_ side and one
// result beat leaves on the m_ side. Each sample goes through four
// registered stages: error, clamped integral and derivative plus the
// stability counter; the three gain products; their sum (the drive);
// then deadband, scaling and step conversion into the output register.
// A new beat is accepted every cycle unless the full pipeline is stalled on
// m_tready; each result passes through the stage 1, 2 and 3 registers and
// then the output register. Each stage moves on whenever the stage after it is
// empty or moving, so a result waiting on m_tready does not block intake
// until all four stages are full. Configuration is written through
// cfg_write/cfg_index/cfg_data; the user must do so only while no beat
// is in flight, which the block does not enforce; indexes beyond the list are ignored.
module pid_valve_step_controller_top
  import pvsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // config write port
  input  logic                cfg_write,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data,
  // sample input
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [23:0]         s_tdata,   // [23:0] measured_flow
  // result output
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata    // [11:0] step_count, [12] move_dir,
                                         // [13] move_request, [14] stable_reached
);

  // ---------------------------------------------------------------- config
  logic signed [FLOW_W-1:0] set_point;
  logic signed [GAIN_W-1:0] gain_p, gain_i, gain_d;
  logic                     settle_mode;
  logic [TOL_W-1:0]         settle_tolerance;
  logic [CNT_W-1:0]         settle_count_target;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_point           <= '0;
      gain_p              <= '0;
      gain_i              <= '0;
      gain_d              <= '0;
      settle_mode         <= 1'b0;
      settle_tolerance    <= '0;
      settle_count_target <= CNT_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SET_POINT:    set_point           <= cfg_data[FLOW_W-1:0];
        REG_GAIN_P:       gain_p              <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:       gain_i              <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:       gain_d              <= cfg_data[GAIN_W-1:0];
        REG_SETTLE_MODE:  settle_mode         <= cfg_data[0];
        REG_SETTLE_TOL:   settle_tolerance    <= cfg_data[TOL_W-1:0];
        REG_COUNT_TARGET: settle_count_target <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ stall chain
  // en3 loads the output register, en2 stage 3, en1 stage 2, s_tready stage 1
  logic v1, v2, v3, ov;
  logic en1, en2, en3;
  logic in_beat;

  assign en3      = !ov || m_tready;
  assign en2      = !v3 || en3;
  assign en1      = !v2 || en2;
  assign s_tready = !v1 || en1;
  assign in_beat  = s_tvalid && s_tready;

  // ------------------------------------------------------ stage 1: error
  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [ERR_W-1:0]   last_error;
  logic [CNT_W-1:0]          stable_run;

  logic signed [ERR_W-1:0]   err;
  logic signed [DERIV_W-1:0] integ_raw;
  logic signed [INTEG_W-1:0] integ_next;
  logic signed [DERIV_W-1:0] deriv;
  logic [ERR_W-1:0]          abs_err;
  logic [CNT_W-1:0]          stable_run_next;

  localparam logic signed [DERIV_W-1:0] INTEG_HI = DERIV_W'(INTEG_LIMIT);
  localparam logic signed [DERIV_W-1:0] INTEG_LO = -DERIV_W'(INTEG_LIMIT);

  always_comb begin
    err       = ERR_W'(set_point) - ERR_W'($signed(s_tdata[FLOW_W-1:0]));
    integ_raw = DERIV_W'(integral_sum) + DERIV_W'(err);
    if (integ_raw > INTEG_HI)      integ_next = INTEG_W'(INTEG_HI);
    else if (integ_raw < INTEG_LO) integ_next = INTEG_W'(INTEG_LO);
    else                           integ_next = INTEG_W'(integ_raw);
    deriv   = DERIV_W'(err) - DERIV_W'(last_error);
    abs_err = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    // run mode holds the count at zero
    if (!settle_mode)                              stable_run_next = '0;
    else if (abs_err < ERR_W'(settle_tolerance))
      stable_run_next = (&stable_run) ? stable_run : stable_run + CNT_W'(1);
    else                                           stable_run_next = '0;
  end

  logic signed [ERR_W-1:0]   e1;
  logic signed [INTEG_W-1:0] i1;
  logic signed [DERIV_W-1:0] d1;
  logic                      dead1, stable1, settle1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      integral_sum <= '0;
      last_error   <= '0;
      stable_run   <= '0;
    end else begin
      if (en1 || !v1) v1 <= in_beat;
      if (in_beat) begin
        integral_sum <= integ_next;
        last_error   <= err;
        stable_run   <= stable_run_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      e1      <= err;
      i1      <= integ_next;
      d1      <= deriv;
      dead1   <= abs_err < ERR_W'(DEADBAND_Q8);
      stable1 <= settle_mode && (stable_run_next >= settle_count_target);
      settle1 <= settle_mode;
    end
  end

  // --------------------------------------------------- stage 2: products
  logic signed [GAIN_W+ERR_W-1:0]   prod_p;
  logic signed [GAIN_W+INTEG_W-1:0] prod_i;
  logic signed [GAIN_W+DERIV_W-1:0] prod_d;
  logic                             dead2, stable2, settle2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en1) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en1 && v1) begin
      prod_p  <= gain_p * e1;
      prod_i  <= gain_i * i1;
      prod_d  <= gain_d * d1;
      dead2   <= dead1;
      stable2 <= stable1;
      settle2 <= settle1;
    end
  end

  // ------------------------------------------------------ stage 3: drive
  logic signed [DRIVE_W-1:0] drive;
  logic                      dead3, stable3, settle3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en2) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en2 && v2) begin
      drive   <= DRIVE_W'(prod_p) + DRIVE_W'(prod_i) + DRIVE_W'(prod_d);
      dead3   <= dead2;
      stable3 <= stable2;
      settle3 <= settle2;
    end
  end

  // ------------------------------------------- stage 4: steps and output
  localparam int WHOLE_W = DRIVE_W - 16;

  logic [DRIVE_W-1:0] mag;
  logic [WHOLE_W-1:0] whole;      // floor(|drive|) in whole units
  logic               positive;
  logic               zeroed;
  logic [17:0]        div_prod;
  logic [7:0]         div_q;
  logic [STEP_W-1:0]  steps;
  logic               dir;

  always_comb begin
    mag      = drive[DRIVE_W-1] ? DRIVE_W'(-drive) : DRIVE_W'(drive);
    whole    = mag[DRIVE_W-1:16];
    positive = !drive[DRIVE_W-1] && (drive != '0);
    // |drive| < 10.0 exactly when the whole part is below 10
    zeroed   = dead3 || (whole < WHOLE_W'(MIN_DRIVE_INT));
    div_prod = 18'(whole[7:0]) * 18'(DIV5_MUL);
    div_q    = div_prod[DIV5_SHIFT+7:DIV5_SHIFT];
    if (settle3) begin
      dir = positive;
      if (whole > WHOLE_W'(STEP_SATURATION) || whole > WHOLE_W'(STEP_FIELD_MAX))
        steps = (STEP_SATURATION < STEP_FIELD_MAX) ? STEP_W'(STEP_SATURATION)
                                                   : STEP_W'(STEP_FIELD_MAX);
      else
        steps = STEP_W'(whole);
    end else begin
      dir = positive && !zeroed;
      if (zeroed)                                   steps = '0;
      else if (whole >= WHOLE_W'(RUN_DIV_SPAN))     steps = STEP_W'(RUN_STEP_LIMIT);
      else if (div_q > 8'(RUN_STEP_LIMIT))          steps = STEP_W'(RUN_STEP_LIMIT);
      else                                          steps = STEP_W'(div_q);
    end
  end

  logic [STEP_W-1:0] step_count;
  logic              move_dir, move_request, stable_reached, out_settle;

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (en3) ov <= v3;
  end

  always_ff @(posedge clk) begin
    if (en3 && v3) begin
      step_count     <= steps;
      move_dir       <= dir;
      move_request   <= steps != '0;
      stable_reached <= stable3;
      out_settle     <= settle3;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {1'b0, stable_reached, move_request, move_dir, step_count};

  // ------------------------------------------------------------ assertions
  a_integ_bounded: assert property (@(posedge clk) disable iff (rst)
    (integral_sum <= INTEG_W'(INTEG_LIMIT)) && (integral_sum >= -INTEG_W'(INTEG_LIMIT)))
    else $error("integral left its clamp range");

  a_run_result: assert property (@(posedge clk) disable iff (rst)
    (ov && !out_settle) |-> (step_count <= STEP_W'(RUN_STEP_LIMIT)) && !stable_reached)
    else $error("run-mode result out of range");

  a_run_clears_count: assert property (@(posedge clk) disable iff (rst)
    (in_beat && !settle_mode) |=> (stable_run == '0))
    else $error("stability count not cleared in run mode");

  a_stage3_holds: assert property (@(posedge clk) disable iff (rst)
    (v3 && !en3) |=> v3)
    else $error("drive stage dropped while stalled");

  a_request_matches: assert property (@(posedge clk) disable iff (rst)
    (en3 && v3) |=> (move_request == (step_count != '0)))
    else $error("move request disagrees with step count");

endmodule
